[rtl/gab_pkg.sv]
`default_nettype none

package gab_pkg;

    // Sizes fixed by the interface
    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W      = 16;
    localparam int DIM_W       = 4;
    localparam int POS_W       = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Saturation limits of a Q8.8 result
    localparam logic signed [ELEM_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [ELEM_W-1:0] SAT_MIN = 16'sh8000;

    // Configuration reset values
    localparam logic [DIM_W-1:0]         DIM_RST   = 4'd8;
    localparam logic signed [ELEM_W-1:0] ALPHA_RST = 16'sd256;
    localparam logic signed [ELEM_W-1:0] BETA_RST  = 16'sd0;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_LOAD_C = 2'd2,
        KIND_START  = 2'd3
    } gab_kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M_ROWS  = 3'd0,
        REG_K_DEPTH = 3'd1,
        REG_N_COLS  = 3'd2,
        REG_TRANS_A = 3'd3,
        REG_TRANS_B = 3'd4,
        REG_ALPHA   = 3'd5,
        REG_BETA    = 3'd6
    } gab_reg_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } gab_state_t;

    // One operand read slot handed from the sequencer to the datapath
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } gab_issue_t;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                   input logic [DIM_W-1:0] max_d);
        logic [DIM_W-1:0] r;
        begin
            if (d == '0)
                r = 4'd1;
            else if (d > max_d)
                r = max_d;
            else
                r = d;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/gab_ram.sv]
`default_nettype none

module gab_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/gab_mac.sv]
`default_nettype none

module gab_mac #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire gab_pkg::gab_issue_t                  issue,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    a_q,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    b_q,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    c_q,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    alpha,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    beta,
    output logic                                      res_valid,
    output logic signed [gab_pkg::ELEM_W-1:0]         res_value
);

    import gab_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    localparam int SH_W   = ACC_W - 8;
    localparam int AP_W   = ELEM_W + SH_W;
    localparam int SUM_W  = AP_W + 1;
    localparam int S_W    = SUM_W - 8;

    logic                     v1_reg, f1_reg, l1_reg;
    logic                     v2_reg, f2_reg, l2_reg;
    logic                     done_reg;
    logic                     res_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [AP_W-1:0]   aprod_reg;
    logic signed [PROD_W-1:0] bprod_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [S_W-1:0]    sum_sh;
    logic [S_W-16:0]          sum_hi;
    logic                     beta_nz;

    assign beta_nz = (beta != '0);

    // Slot tags follow the read data through the product and accumulate stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            f1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
            done_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= issue.valid;
            f1_reg    <= issue.first;
            l1_reg    <= issue.last;
            v2_reg    <= v1_reg;
            f2_reg    <= f1_reg;
            l2_reg    <= l1_reg;
            done_reg  <= v2_reg && l2_reg;
            res_v_reg <= done_reg;
        end
    end

    // First slot of an element restarts the sum
    assign acc_base = f2_reg ? '0 : acc_reg;

    // Product and exact accumulate
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= a_q * b_q;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
    end

    // Floor shift of the sum before scaling by alpha
    assign acc_sh = acc_reg[ACC_W-1:8];

    // Scale stage: alpha and beta products in parallel
    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            aprod_reg <= alpha * acc_sh;
            if (beta_nz)
            begin
                bprod_reg <= beta * c_q;
            end
            else
            begin
                bprod_reg <= '0;
            end
        end
    end

    // Final add, floor shift and saturation
    assign sum    = SUM_W'(aprod_reg) + SUM_W'(bprod_reg);
    assign sum_sh = sum[SUM_W-1:8];
    assign sum_hi = sum_sh[S_W-1:15];

    always_comb
    begin
        if ((&sum_hi) || (~|sum_hi))
            res_value = sum_sh[ELEM_W-1:0];
        else if (sum_sh[S_W-1])
            res_value = SAT_MIN;
        else
            res_value = SAT_MAX;
    end

    assign res_valid = res_v_reg;

endmodule

`default_nettype wire

[rtl/gab_ctrl.sv]
`default_nettype none

module gab_ctrl #(
    parameter int  MAX_DIM = 8,
    localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [gab_pkg::KIND_W-1:0]          kind,
    input  wire logic [gab_pkg::POS_W-1:0]           row_index,
    input  wire logic [gab_pkg::POS_W-1:0]           col_index,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]   elem_value,
    // configuration
    input  wire logic [gab_pkg::DIM_W-1:0]           m_rows,
    input  wire logic [gab_pkg::DIM_W-1:0]           k_depth,
    input  wire logic [gab_pkg::DIM_W-1:0]           n_cols,
    input  wire logic                                trans_a,
    input  wire logic                                trans_b,
    input  wire logic                                beta_nz,
    // memory control
    output gab_pkg::gab_issue_t                      issue,
    output logic                                     ab_re,
    output logic                                     c_re,
    output logic [AW-1:0]                            a_raddr,
    output logic [AW-1:0]                            b_raddr,
    output logic [AW-1:0]                            c_raddr,
    output logic                                     a_we,
    output logic                                     b_we,
    output logic                                     c_we,
    output logic [AW-1:0]                            waddr,
    output logic signed [gab_pkg::ELEM_W-1:0]        wdata,
    // datapath result
    input  wire logic                                res_valid,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]   res_value,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [gab_pkg::POS_W-1:0]                out_row,
    output logic [gab_pkg::POS_W-1:0]                out_col,
    output logic signed [gab_pkg::ELEM_W-1:0]        out_value,
    output logic                                     last_flag
);

    import gab_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    gab_state_t state_reg, state_next;

    logic [IW-1:0] m_reg, m_next;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] m_last, n_last, k_last;

    logic                     out_valid_reg, out_valid_next;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic signed [ELEM_W-1:0] out_value_reg;
    logic                     last_reg;

    logic elem_last;
    logic out_free;
    logic emit_fire;
    logic in_fire;
    logic load_ok;
    logic load_fire;
    logic [AW-1:0] load_addr;
    logic [AW-1:0] elem_addr;

    function automatic logic [AW-1:0] mk_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
        begin
            return AW'(r) * AW'(MAX_DIM) + AW'(c);
        end
    endfunction

    // Effective last indexes
    assign m_last = IW'(clamp_dim(m_rows,  DIM_W'(MAX_DIM)) - 4'd1);
    assign k_last = IW'(clamp_dim(k_depth, DIM_W'(MAX_DIM)) - 4'd1);
    assign n_last = IW'(clamp_dim(n_cols,  DIM_W'(MAX_DIM)) - 4'd1);

    assign elem_last = (m_reg == m_last) && (n_reg == n_last);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign load_ok   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign load_fire = in_fire && (kind != KIND_START) && load_ok;
    assign load_addr = mk_addr(IW'(row_index), IW'(col_index));
    assign elem_addr = mk_addr(m_reg, n_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && kind == KIND_START)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (k_reg == k_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (res_valid)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = elem_last ? ST_IDLE : ST_ISSUE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Loop counters: k inner, then n, then m
    always_comb
    begin
        m_next = m_reg;
        n_next = n_reg;
        k_next = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                m_next = '0;
                n_next = '0;
                k_next = '0;
            end
            ST_ISSUE:
            begin
                k_next = (k_reg == k_last) ? '0 : IW'(k_reg + 1'b1);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (n_reg == n_last)
                    begin
                        n_next = '0;
                        m_next = IW'(m_reg + 1'b1);
                    end
                    else
                    begin
                        n_next = IW'(n_reg + 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        issue.valid = (state_reg == ST_ISSUE);
        issue.first = (k_reg == '0);
        issue.last  = (k_reg == k_last);
        ab_re       = issue.valid;
        c_re        = issue.valid && issue.first && beta_nz;
        a_raddr     = trans_a ? mk_addr(k_reg, m_reg) : mk_addr(m_reg, k_reg);
        b_raddr     = trans_b ? mk_addr(n_reg, k_reg) : mk_addr(k_reg, n_reg);
        c_raddr     = elem_addr;
        a_we        = load_fire && (kind == KIND_LOAD_A);
        b_we        = load_fire && (kind == KIND_LOAD_B);
        c_we        = (load_fire && (kind == KIND_LOAD_C)) || emit_fire;
        waddr       = emit_fire ? elem_addr : load_addr;
        wdata       = emit_fire ? res_value : elem_value;
    end

    // Result register valid
    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg   <= POS_W'(m_reg);
            out_col_reg   <= POS_W'(n_reg);
            out_value_reg <= res_value;
            last_reg      <= elem_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last_flag = last_reg;

    // A and B are only written between starts
    a_ab_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (a_we || b_we) |-> state_reg == ST_IDLE)
        else $error("A/B store written during compute");

    // Datapath result only arrives while waiting for it
    a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == ST_WAIT)
        else $error("datapath result outside wait state");

    // Last operand slot hands over to the wait state
    a_issue_end: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.last) |=> state_reg == ST_WAIT)
        else $error("issue did not end after last slot");

    // Final element is presented flagged and the sequencer goes idle
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && elem_last) |=> (state_reg == ST_IDLE && out_valid && last_flag))
        else $error("final element not flagged or sequencer not idle");

endmodule

`default_nettype wire

[rtl/gemm_alpha_beta_transpose_unit.sv]
// Load request: accepted while the unit is idle, no result.
// Start request: each C element takes K operand reads from the A and B memory ports,
// then passes the multiply/accumulate/scale pipeline and a write-back step,
// and a start can also stall on the result channel.
// Reset (rst_n, async, active low) clears control and configuration; stores are not cleared.
`default_nettype none

module gemm_alpha_beta_transpose_unit #(
    parameter int MAX_DIM = gab_pkg::MAX_DIM_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // request channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [gab_pkg::KIND_W-1:0]           kind,
    input  wire logic [gab_pkg::POS_W-1:0]            row_index,
    input  wire logic [gab_pkg::POS_W-1:0]            col_index,
    input  wire logic signed [gab_pkg::ELEM_W-1:0]    elem_value,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [gab_pkg::POS_W-1:0]                 out_row,
    output logic [gab_pkg::POS_W-1:0]                 out_col,
    output logic signed [gab_pkg::ELEM_W-1:0]         out_value,
    output logic                                      last_flag,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [gab_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gab_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import gab_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0]         m_rows_reg, k_depth_reg, n_cols_reg;
    logic                     trans_a_reg, trans_b_reg;
    logic signed [ELEM_W-1:0] alpha_reg, beta_reg;
    logic                     beta_nz;

    gab_issue_t               issue;
    logic                     ab_re, c_re;
    logic [AW-1:0]            a_raddr, b_raddr, c_raddr;
    logic                     a_we, b_we, c_we;
    logic [AW-1:0]            waddr;
    logic signed [ELEM_W-1:0] wdata;
    logic [ELEM_W-1:0]        a_rd, b_rd, c_rd;
    logic                     res_valid;
    logic signed [ELEM_W-1:0] res_value;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_rows_reg  <= DIM_RST;
            k_depth_reg <= DIM_RST;
            n_cols_reg  <= DIM_RST;
            trans_a_reg <= 1'b0;
            trans_b_reg <= 1'b0;
            alpha_reg   <= ALPHA_RST;
            beta_reg    <= BETA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_M_ROWS:  m_rows_reg  <= cfg_data[DIM_W-1:0];
                REG_K_DEPTH: k_depth_reg <= cfg_data[DIM_W-1:0];
                REG_N_COLS:  n_cols_reg  <= cfg_data[DIM_W-1:0];
                REG_TRANS_A: trans_a_reg <= cfg_data[0];
                REG_TRANS_B: trans_b_reg <= cfg_data[0];
                REG_ALPHA:   alpha_reg   <= cfg_data;
                REG_BETA:    beta_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign beta_nz = (beta_reg != '0);

    // Sequencer
    gab_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .m_rows     (m_rows_reg),
        .k_depth    (k_depth_reg),
        .n_cols     (n_cols_reg),
        .trans_a    (trans_a_reg),
        .trans_b    (trans_b_reg),
        .beta_nz    (beta_nz),
        .issue      (issue),
        .ab_re      (ab_re),
        .c_re       (c_re),
        .a_raddr    (a_raddr),
        .b_raddr    (b_raddr),
        .c_raddr    (c_raddr),
        .a_we       (a_we),
        .b_we       (b_we),
        .c_we       (c_we),
        .waddr      (waddr),
        .wdata      (wdata),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .last_flag  (last_flag)
    );

    // Operand and result stores
    gab_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_W)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ab_re),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    gab_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_W)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ab_re),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    gab_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_W)
    ) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rd)
    );

    // Multiply-accumulate and scaling datapath
    gab_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .a_q       (signed'(a_rd)),
        .b_q       (signed'(b_rd)),
        .c_q       (signed'(c_rd)),
        .alpha     (alpha_reg),
        .beta      (beta_reg),
        .res_valid (res_valid),
        .res_value (res_value)
    );

endmodule

`default_nettype wire

[tb/tb_gemm_alpha_beta_transpose_unit.sv]
`timescale 1ns / 100ps

module tb_gemm_alpha_beta_transpose_unit;

    import gab_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;

    // One emitted C element
    typedef struct packed {
        logic [2:0]        row;
        logic [2:0]        col;
        logic signed [15:0] value;
        logic              last;
    } c_elem_t;

    // One planned load request
    typedef struct packed {
        gab_kind_t  k;
        logic [2:0] r;
        logic [2:0] c;
    } load_t;

    // One line of the directed table: a register write or a request
    typedef struct {
        bit                 is_cfg;
        gab_reg_t           idx;
        logic [15:0]        cfg_val;
        gab_kind_t          k;
        logic [2:0]         r;
        logic [2:0]         c;
        logic [15:0]        v;
        bit                 typed;
        logic [15:0]        want;
    } dir_row_t;

    // DUT connections
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  kind       = '0;
    logic [2:0]  row_index  = '0;
    logic [2:0]  col_index  = '0;
    logic signed [15:0] elem_value = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic signed [15:0] out_value;
    logic        last_flag;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;

    // Shadow of the block: stores, written marks, configuration
    logic signed [15:0] a_mem [64];
    logic signed [15:0] b_mem [64];
    logic signed [15:0] c_mem [64];
    bit                 a_set [64];
    bit                 b_set [64];
    bit                 c_set [64];
    logic [3:0]         m_cfg = 4'd8;
    logic [3:0]         k_cfg = 4'd8;
    logic [3:0]         n_cfg = 4'd8;
    bit                 ta_cfg = 1'b0;
    bit                 tb_cfg = 1'b0;
    logic signed [15:0] alpha_cfg = 16'sd256;
    logic signed [15:0] beta_cfg  = 16'sd0;

    c_elem_t  pending_c_q [$];
    dir_row_t dir_q [$];

    int errors       = 0;
    int reqs_sent    = 0;
    int starts_sent  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    gemm_alpha_beta_transpose_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .last_flag  (last_flag),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 0 acts as 1, above 8 acts as 8
    function automatic int eff_dim(input logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (d > 4'd8)
            return 8;
        return int'(d);
    endfunction

    function automatic logic [3:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            return 4'd0;
        if (sel == 1)
            return 4'($urandom_range(8, 15));
        return 4'($urandom_range(1, 4));
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale(input bit allow_zero);
        case ($urandom_range(0, 9))
            0:       return allow_zero ? 16'h0000 : 16'h0100;
            1:       return allow_zero ? 16'h0000 : 16'h0100;
            2:       return 16'h0100;
            3:       return 16'h7fff;
            4:       return 16'h8000;
            5:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    function automatic dir_row_t op_req(input gab_kind_t k, input logic [2:0] r,
                                        input logic [2:0] c, input logic [15:0] v,
                                        input bit typed = 1'b0,
                                        input logic [15:0] want = 16'h0000);
        dir_row_t d;
        d.is_cfg  = 1'b0;
        d.idx     = REG_M_ROWS;
        d.cfg_val = '0;
        d.k       = k;
        d.r       = r;
        d.c       = c;
        d.v       = v;
        d.typed   = typed;
        d.want    = want;
        return d;
    endfunction

    function automatic dir_row_t op_cfg(input gab_reg_t idx, input logic [15:0] val);
        dir_row_t d;
        d = op_req(KIND_LOAD_A, 3'd0, 3'd0, 16'h0000);
        d.is_cfg  = 1'b1;
        d.idx     = idx;
        d.cfg_val = val;
        return d;
    endfunction

    // Shadow update for one accepted request; a start queues its C elements
    task automatic apply_request(input gab_kind_t k, input logic [2:0] r, input logic [2:0] c,
                                 input logic signed [15:0] v, input bit typed,
                                 input logic signed [15:0] want);
        int em, ek, en, mi, ni, ki, ai, bi;
        longint acc, sum;
        c_elem_t e;
        case (k)
            KIND_LOAD_A:
            begin
                a_mem[{r, c}] = v;
                a_set[{r, c}] = 1'b1;
            end
            KIND_LOAD_B:
            begin
                b_mem[{r, c}] = v;
                b_set[{r, c}] = 1'b1;
            end
            KIND_LOAD_C:
            begin
                c_mem[{r, c}] = v;
                c_set[{r, c}] = 1'b1;
            end
            KIND_START:
            begin
                em = eff_dim(m_cfg);
                ek = eff_dim(k_cfg);
                en = eff_dim(n_cfg);
                for (mi = 0; mi < em; mi++)
                begin
                    for (ni = 0; ni < en; ni++)
                    begin
                        acc = 0;
                        for (ki = 0; ki < ek; ki++)
                        begin
                            ai = ta_cfg ? ki * 8 + mi : mi * 8 + ki;
                            bi = tb_cfg ? ni * 8 + ki : ki * 8 + ni;
                            acc += longint'(a_mem[ai]) * longint'(b_mem[bi]);
                        end
                        sum = longint'(alpha_cfg) * (acc >>> 8);
                        if (beta_cfg != 0)
                            sum += longint'(beta_cfg) * longint'(c_mem[mi * 8 + ni]);
                        sum = sum >>> 8;
                        if (sum > 32767)
                            sum = 32767;
                        else if (sum < -32768)
                            sum = -32768;
                        c_mem[mi * 8 + ni] = 16'(sum);
                        c_set[mi * 8 + ni] = 1'b1;
                        e.row   = 3'(mi);
                        e.col   = 3'(ni);
                        e.value = typed ? want : 16'(sum);
                        e.last  = (mi == em - 1) && (ni == en - 1);
                        pending_c_q.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request, wait for it to be taken, then update the shadow
    task automatic send_req(input gab_kind_t k, input logic [2:0] r, input logic [2:0] c,
                            input logic [15:0] v, input bit typed = 1'b0,
                            input logic [15:0] want = 16'h0000);
        cfg_we <= 1'b0;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        row_index  <= r;
        col_index  <= c;
        elem_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        reqs_sent++;
        if (k == KIND_START)
            starts_sent++;
        apply_request(k, r, c, v, typed, want);
    endtask

    task automatic write_reg(input gab_reg_t idx, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            REG_M_ROWS:  m_cfg = d[3:0];
            REG_K_DEPTH: k_cfg = d[3:0];
            REG_N_COLS:  n_cfg = d[3:0];
            REG_TRANS_A: ta_cfg = d[0];
            REG_TRANS_B: tb_cfg = d[0];
            REG_ALPHA:   alpha_cfg = d;
            REG_BETA:    beta_cfg = d;
            default: ;
        endcase
    endtask

    // Drain all expected elements, then let the pipeline settle
    task automatic quiesce();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_c_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random job: new config, operand loads in stored layout, then in most jobs a start
    task automatic run_job(input bit squeeze);
        logic [3:0] dm, dk, dn;
        logic [15:0] al, be;
        bit ta, tb;
        int em, ek, en, r, c, j;
        load_t plan [$];
        load_t tmp;
        quiesce();
        dm = pick_dim();
        dk = pick_dim();
        dn = pick_dim();
        ta = $urandom_range(0, 1);
        tb = $urandom_range(0, 1);
        al = pick_scale(1'b0);
        be = pick_scale(1'b1);
        write_reg(REG_M_ROWS, 16'(dm) | (16'($urandom) & 16'hfff0));
        write_reg(REG_K_DEPTH, 16'(dk));
        write_reg(REG_N_COLS, 16'(dn));
        write_reg(REG_TRANS_A, 16'(ta));
        write_reg(REG_TRANS_B, 16'(tb));
        write_reg(REG_ALPHA, al);
        write_reg(REG_BETA, be);
        em = eff_dim(dm);
        ek = eff_dim(dk);
        en = eff_dim(dn);

        // entries the start will read, some rewrites of held ones and up to three stray loads, shuffled
        for (r = 0; r < (ta ? ek : em); r++)
            for (c = 0; c < (ta ? em : ek); c++)
                if (!a_set[r * 8 + c] || $urandom_range(0, 1))
                    plan.push_back('{KIND_LOAD_A, 3'(r), 3'(c)});
        for (r = 0; r < (tb ? en : ek); r++)
            for (c = 0; c < (tb ? ek : en); c++)
                if (!b_set[r * 8 + c] || $urandom_range(0, 1))
                    plan.push_back('{KIND_LOAD_B, 3'(r), 3'(c)});
        if (be != 16'h0000)
            for (r = 0; r < em; r++)
                for (c = 0; c < en; c++)
                    if (!c_set[r * 8 + c] || $urandom_range(0, 2) == 0)
                        plan.push_back('{KIND_LOAD_C, 3'(r), 3'(c)});
        for (j = $urandom_range(0, 3); j > 0; j--)
            plan.push_back('{gab_kind_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom)});
        for (j = plan.size() - 1; j > 0; j--)
        begin
            r = $urandom_range(0, j);
            tmp = plan[j];
            plan[j] = plan[r];
            plan[r] = tmp;
        end
        foreach (plan[i])
            send_req(plan[i].k, plan[i].r, plan[i].c, pick_value());

        // hold results back so the block fills and blocks further requests
        if (squeeze)
            hold_req <= hold_req + 1;

        // occasionally a job ends without a start
        if (squeeze || $urandom_range(0, 9) != 0)
        begin
            send_req(KIND_START, 3'($urandom), 3'($urandom), 16'($urandom));
            if (squeeze || $urandom_range(0, 5) == 0)
                send_req(KIND_START, 3'($urandom), 3'($urandom), 16'($urandom));
            if (squeeze)
                for (j = 0; j < 4; j++)
                    send_req(gab_kind_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom),
                             pick_value());
        end
    endtask

    // Result side ready, with random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic log_mismatch(input string what, input c_elem_t want);
        errors++;
        if (errors <= 10)
            $display("%0t %s: want r%0d c%0d v%0d last%0b, got r%0d c%0d v%0d last%0b",
                     $time, what, want.row, want.col, want.value, want.last,
                     out_row, out_col, out_value, last_flag);
    endtask

    // Compare each taken result with the oldest expected element
    always @(posedge clk)
    begin : result_check
        c_elem_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_c_q.size() == 0)
                log_mismatch("unexpected result", '0);
            else
            begin
                want = pending_c_q.pop_front();
                if (out_row !== want.row || out_col !== want.col ||
                    out_value !== want.value || last_flag !== want.last)
                    log_mismatch("result mismatch", want);
            end
        end
    end

    // Cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("timeout: no request or result for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int i, p;
        bit cfg_open;
        bit squeezed;
        cfg_open = 1'b0;
        squeezed = 1'b0;

        // 1x1x1: saturation both ways, unity, floor rounding, beta and write back
        dir_q.push_back(op_cfg(REG_M_ROWS,  16'd1));
        dir_q.push_back(op_cfg(REG_K_DEPTH, 16'd1));
        dir_q.push_back(op_cfg(REG_N_COLS,  16'd1));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd0, 16'h7fff));
        dir_q.push_back(op_req(KIND_LOAD_B, 3'd0, 3'd0, 16'h7fff));
        dir_q.push_back(op_req(KIND_START,  3'd7, 3'd7, 16'hffff, 1'b1, 16'h7fff));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd0, 16'h8000));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000, 1'b1, 16'h8000));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd0, 16'h0100));
        dir_q.push_back(op_req(KIND_LOAD_B, 3'd0, 3'd0, 16'h0100));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000, 1'b1, 16'h0100));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd0, 16'hffff));
        dir_q.push_back(op_req(KIND_LOAD_B, 3'd0, 3'd0, 16'h0001));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000, 1'b1, 16'hffff));
        dir_q.push_back(op_cfg(REG_BETA,    16'h0100));
        dir_q.push_back(op_req(KIND_LOAD_C, 3'd0, 3'd0, 16'd100));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000, 1'b1, 16'd99));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000, 1'b1, 16'd98));
        // 2x2 with K of zero, both transposed, most negative alpha and beta
        dir_q.push_back(op_cfg(REG_M_ROWS,  16'd2));
        dir_q.push_back(op_cfg(REG_K_DEPTH, 16'd0));
        dir_q.push_back(op_cfg(REG_N_COLS,  16'd2));
        dir_q.push_back(op_cfg(REG_TRANS_A, 16'd1));
        dir_q.push_back(op_cfg(REG_TRANS_B, 16'd1));
        dir_q.push_back(op_cfg(REG_ALPHA,   16'h8000));
        dir_q.push_back(op_cfg(REG_BETA,    16'h0000));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd1, 16'h1234));
        dir_q.push_back(op_req(KIND_LOAD_B, 3'd1, 3'd0, 16'hfa99));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000));
        dir_q.push_back(op_cfg(REG_BETA,    16'h8000));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000));
        // M above the maximum acts as 8, largest alpha
        dir_q.push_back(op_cfg(REG_M_ROWS,  16'd15));
        dir_q.push_back(op_cfg(REG_K_DEPTH, 16'd1));
        dir_q.push_back(op_cfg(REG_N_COLS,  16'd1));
        dir_q.push_back(op_cfg(REG_TRANS_B, 16'd0));
        dir_q.push_back(op_cfg(REG_ALPHA,   16'h7fff));
        dir_q.push_back(op_cfg(REG_BETA,    16'h0000));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd2, 16'h7fff));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd3, 16'h8000));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd4, 16'h0001));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd5, 16'hff00));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd6, 16'h00ff));
        dir_q.push_back(op_req(KIND_LOAD_A, 3'd0, 3'd7, 16'h4000));
        dir_q.push_back(op_req(KIND_START,  3'd0, 3'd0, 16'h0000));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < dir_q.size(); i++)
        begin
            if (dir_q[i].is_cfg)
            begin
                if (!cfg_open)
                    quiesce();
                write_reg(dir_q[i].idx, dir_q[i].cfg_val);
                cfg_open = 1'b1;
            end
            else
            begin
                cfg_open = 1'b0;
                send_req(dir_q[i].k, dir_q[i].r, dir_q[i].c, dir_q[i].v,
                         dir_q[i].typed, dir_q[i].want);
            end
        end

        // random jobs under four pacing phases
        for (p = 0; p < 4; p++)
        begin
            quiesce();
            case (p)
                0:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  <= 45;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 45;
                end
                default:
                begin
                    send_idle_pct  <= 29;
                    recv_stall_pct <= 29;
                end
            endcase
            @(posedge clk);
            while (reqs_sent < 25 + (p + 1) * 109)
            begin
                run_job(p == 2 && !squeezed);
                if (p == 2)
                    squeezed = 1'b1;
            end
        end

        quiesce();
        errors += pending_c_q.size();
        $display("Covered %0d requests (%0d starts), %0d C elements checked", reqs_sent,
                 starts_sent, results_seen);
        $display("Four pacing phases plus one long result hold-off; %0d failures", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/gab_pkg.sv
rtl/gab_ram.sv
rtl/gab_mac.sv
rtl/gab_ctrl.sv
rtl/gemm_alpha_beta_transpose_unit.sv
tb/tb_gemm_alpha_beta_transpose_unit.sv
